### rtl/ordered_list_buffer_defines.svh
// Assertion macros used by the ordered list buffer checker.
`ifndef ORDERED_LIST_BUFFER_DEFINES_SVH
`define ORDERED_LIST_BUFFER_DEFINES_SVH

// Check a same-cycle implication on every clock edge outside reset.
`define OLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication that must hold in the following cycle.
`define OLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/olb_pkg.sv
// Shared types and constants of the ordered list buffer.
package olb_pkg;

    // Store geometry
    localparam int DEPTH     = 16;
    localparam int WIDTH     = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = 5;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 5;
    localparam int CMP_W     = (CNT_W > POS_W) ? ((CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W)
                                               : ((POS_W > CNT_OUT_W) ? POS_W : CNT_OUT_W);

    // Command codes
    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_PUSH   = 3'd3,
        CMD_POP    = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    // Output register occupancy
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_HOLD = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    rd;
        logic    ins;
        logic    ers;
        logic    push;
        logic    pop;
        logic    clr;
        t_status status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_gt_cnt;
        logic pos_ge_cnt;
    } t_dp_stat;

endpackage

### rtl/ordered_list_buffer.sv
// Top level of the ordered list buffer: controller plus cell datapath.
//
//  channel | direction | handshake              | fields
//  --------+-----------+------------------------+--------------------------------------------
//  in      | to block  | i_in_valid/o_in_stall  | i_cmd, i_position, i_element_value
//  out     | from block| o_out_valid/i_out_stall| o_read_value, o_status, o_count, o_is_empty
//
// Each command completes in the result register: every cell shifts in parallel, so
// a word accepted at one edge shows its result after that edge, one result per
// cycle unless the output side stalls. The result register is the only stage;
// input stalls only while a result waits and the output side stalls.
// Synchronous active-low reset empties the store and drops any pending result;
// cell contents are not cleared and are never read past the fill count.
module ordered_list_buffer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_cmd,
    input  logic [olb_pkg::POS_W-1:0]       i_position,
    input  logic [olb_pkg::VAL_W-1:0]       i_element_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [olb_pkg::VAL_W-1:0]       o_read_value,
    output logic [1:0]                      o_status,
    output logic [olb_pkg::CNT_OUT_W-1:0]   o_count,
    output logic                            o_is_empty
);

    olb_pkg::t_dp_cmd  dp_cmd;
    olb_pkg::t_dp_stat dp_stat;

    // Sequence handshakes and validate commands
    olb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_dp_stat   (dp_stat),
        .o_dp_cmd    (dp_cmd)
    );

    // Hold the cells and the result word
    olb_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_position      (i_position),
        .i_element_value (i_element_value),
        .i_dp_cmd        (dp_cmd),
        .o_dp_stat       (dp_stat),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_count         (o_count),
        .o_is_empty      (o_is_empty)
    );

endmodule

### rtl/olb_ctrl.sv
// Controller of the ordered list buffer: handshake, command checks, output occupancy.
module olb_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_cmd,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  olb_pkg::t_dp_stat           i_dp_stat,
    output olb_pkg::t_dp_cmd            o_dp_cmd
);

    olb_pkg::t_state r_state;
    olb_pkg::t_state n_state;
    logic            accept;

    // Hold the output register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Stall input only while a result waits and the consumer stalls
    assign o_in_stall  = (r_state == olb_pkg::ST_HOLD) && i_out_stall;
    assign o_out_valid = (r_state == olb_pkg::ST_HOLD);
    assign accept      = i_in_valid && !o_in_stall;

    // Decode the command, check its bounds and advance the state
    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        o_dp_cmd.status = olb_pkg::STAT_OK;

        case (r_state)
            olb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = olb_pkg::ST_HOLD;
                end
            end
            olb_pkg::ST_HOLD: begin
                if (!accept && !i_out_stall) begin
                    n_state = olb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = olb_pkg::ST_IDLE;
            end
        endcase

        if (accept) begin
            o_dp_cmd.load = 1'b1;
            case (i_cmd)
                olb_pkg::CMD_READ: begin
                    if (i_dp_stat.pos_ge_cnt) begin
                        o_dp_cmd.status = olb_pkg::STAT_RANGE;
                    end else begin
                        o_dp_cmd.rd = 1'b1;
                    end
                end
                olb_pkg::CMD_INSERT: begin
                    if (i_dp_stat.pos_gt_cnt) begin
                        o_dp_cmd.status = olb_pkg::STAT_RANGE;
                    end else if (i_dp_stat.full) begin
                        o_dp_cmd.status = olb_pkg::STAT_FULL;
                    end else begin
                        o_dp_cmd.ins = 1'b1;
                    end
                end
                olb_pkg::CMD_ERASE: begin
                    if (i_dp_stat.pos_ge_cnt) begin
                        o_dp_cmd.status = olb_pkg::STAT_RANGE;
                    end else begin
                        o_dp_cmd.ers = 1'b1;
                    end
                end
                olb_pkg::CMD_PUSH: begin
                    if (i_dp_stat.full) begin
                        o_dp_cmd.status = olb_pkg::STAT_FULL;
                    end else begin
                        o_dp_cmd.push = 1'b1;
                    end
                end
                olb_pkg::CMD_POP: begin
                    if (i_dp_stat.empty) begin
                        o_dp_cmd.status = olb_pkg::STAT_EMPTY;
                    end else begin
                        o_dp_cmd.pop = 1'b1;
                    end
                end
                olb_pkg::CMD_CLEAR: begin
                    o_dp_cmd.clr = 1'b1;
                end
                default: begin
                    // unused codes leave the store alone
                end
            endcase
        end
    end

endmodule

### rtl/olb_datapath.sv
// Datapath of the ordered list buffer: shifting cell row, fill count, output register.
module olb_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [olb_pkg::POS_W-1:0]       i_position,
    input  logic [olb_pkg::VAL_W-1:0]       i_element_value,
    input  olb_pkg::t_dp_cmd                i_dp_cmd,
    output olb_pkg::t_dp_stat               o_dp_stat,
    output logic [olb_pkg::VAL_W-1:0]       o_read_value,
    output logic [1:0]                      o_status,
    output logic [olb_pkg::CNT_OUT_W-1:0]   o_count,
    output logic                            o_is_empty
);

    localparam int CMP_W = olb_pkg::CMP_W;
    localparam int IDX_W = olb_pkg::IDX_W;
    localparam int CNT_W = olb_pkg::CNT_W;
    localparam int WIDTH = olb_pkg::WIDTH;
    localparam int DEPTH = olb_pkg::DEPTH;

    logic [WIDTH-1:0]         r_cells [DEPTH];
    logic [WIDTH-1:0]         n_cells [DEPTH];
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic [olb_pkg::VAL_W-1:0] r_read_value;
    olb_pkg::t_status         r_status;
    logic [olb_pkg::CNT_OUT_W-1:0] r_count;
    logic                     r_is_empty;

    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         n_cnt_ext;
    logic [IDX_W-1:0]         pos_idx;
    logic [IDX_W-1:0]         cnt_idx;
    logic [WIDTH-1:0]         wr_val;
    logic [olb_pkg::VAL_W-1:0] rd_val;

    // Widen position and count to a common compare width
    assign pos_ext   = CMP_W'(i_position);
    assign cnt_ext   = CMP_W'(r_cnt);
    assign n_cnt_ext = CMP_W'(n_cnt);
    assign pos_idx   = pos_ext[IDX_W-1:0];
    assign cnt_idx   = cnt_ext[IDX_W-1:0];
    assign wr_val    = WIDTH'(i_element_value);
    assign rd_val    = olb_pkg::VAL_W'(r_cells[pos_idx]);

    // Report bounds to the controller
    assign o_dp_stat.full       = (cnt_ext == CMP_W'(DEPTH));
    assign o_dp_stat.empty      = (r_cnt == '0);
    assign o_dp_stat.pos_gt_cnt = (pos_ext > cnt_ext);
    assign o_dp_stat.pos_ge_cnt = (pos_ext >= cnt_ext);

    // Shift the cell row up or down and write new words
    always_comb begin
        n_cells = r_cells;
        if (i_dp_cmd.ins) begin
            for (int i = 1; i < DEPTH; i++) begin
                if (CMP_W'(i) > pos_ext) begin
                    n_cells[i] = r_cells[i-1];
                end
            end
            n_cells[pos_idx] = wr_val;
        end
        if (i_dp_cmd.ers) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (CMP_W'(i) >= pos_ext) begin
                    n_cells[i] = r_cells[i+1];
                end
            end
        end
        if (i_dp_cmd.push) begin
            n_cells[cnt_idx] = wr_val;
        end
    end

    // Advance the fill count
    always_comb begin
        n_cnt = r_cnt;
        if (i_dp_cmd.clr) begin
            n_cnt = '0;
        end else if (i_dp_cmd.ins || i_dp_cmd.push) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_dp_cmd.ers || i_dp_cmd.pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    // Hold cell contents
    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
    end

    // Hold the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Load the result word on accept
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_read_value <= i_dp_cmd.rd ? rd_val : '0;
            r_status     <= i_dp_cmd.status;
            r_count      <= n_cnt_ext[olb_pkg::CNT_OUT_W-1:0];
            r_is_empty   <= (n_cnt == '0);
        end
    end

    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count;
    assign o_is_empty   = r_is_empty;

endmodule

### rtl/olb_checker.sv
// Port-level checks of the ordered list buffer and their bind.
`include "ordered_list_buffer_defines.svh"

module olb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [olb_pkg::VAL_W-1:0]       o_read_value,
    input  logic [1:0]                      o_status,
    input  logic [olb_pkg::CNT_OUT_W-1:0]   o_count,
    input  logic                            o_is_empty
);

    // Empty flag must agree with the count
    `OLB_ASSERT_NOW(a_empty_flag, o_out_valid, o_is_empty == (o_count == '0), "empty flag mismatch")

    // A rejected command returns no read data
    `OLB_ASSERT_NOW(a_reject_zero, o_out_valid && (o_status != olb_pkg::STAT_OK), o_read_value == '0, "rejected word carries data")

    // Input stalls only behind a stalled pending result
    `OLB_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without cause")

    // An accepted word yields a result on the next cycle
    `OLB_ASSERT_NEXT(a_accept_result, i_in_valid && !o_in_stall, o_out_valid, "accepted word lost")

    // A stalled result stays valid
    `OLB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "stalled result dropped")

endmodule

bind ordered_list_buffer olb_checker u_olb_checker (.*);
